// ===== rtl/fh64_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fh64_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned HALF_W = WORD_W / 2;
  localparam int unsigned LEN_W  = 13;
  localparam int unsigned CNT_W  = 4;

  localparam logic [WORD_W-1:0] HASH_M = 64'h8803_55f2_1e6d_1965;
  localparam logic [WORD_W-1:0] MIX_K  = 64'h2127_599b_f432_5c37;
  localparam int unsigned SHIFT_A = 23;
  localparam int unsigned SHIFT_B = 47;

  typedef logic [WORD_W-1:0] word_t;

  // handshake between the sequencer and the shared multiplier
  typedef struct packed {
    logic  start;
    word_t op_a;
    word_t op_b;
  } mul_req_t;

  typedef struct packed {
    logic  busy;
    logic  done;
    word_t product;
  } mul_rsp_t;

  function automatic word_t xs_a(input word_t v);
    xs_a = v ^ (v >> SHIFT_A);
  endfunction

  function automatic word_t xs_b(input word_t v);
    xs_b = v ^ (v >> SHIFT_B);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fh64_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

// 64x64 -> low 64 bits, built from three 32x32 partial products on one
// multiplier, one per cycle. done pulses once the third partial product is added.
module fh64_mul (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire fh64_pkg::mul_req_t req,
  output fh64_pkg::mul_rsp_t     rsp
);

  typedef enum logic [1:0] {
    ST_LL,
    ST_LH,
    ST_HL
  } step_t;

  fh64_pkg::word_t                  a_r, b_r, acc_r, acc_nxt;
  step_t                            step_r;
  logic                             busy_r, done_r;
  logic [fh64_pkg::HALF_W-1:0]      pa, pb;
  logic [fh64_pkg::WORD_W-1:0]      pp;

  always_comb begin
    case (step_r)
      ST_LL: begin
        pa = a_r[fh64_pkg::HALF_W-1:0];
        pb = b_r[fh64_pkg::HALF_W-1:0];
      end
      ST_LH: begin
        pa = a_r[fh64_pkg::HALF_W-1:0];
        pb = b_r[fh64_pkg::WORD_W-1:fh64_pkg::HALF_W];
      end
      ST_HL: begin
        pa = a_r[fh64_pkg::WORD_W-1:fh64_pkg::HALF_W];
        pb = b_r[fh64_pkg::HALF_W-1:0];
      end
      default: begin
        pa = '0;
        pb = '0;
      end
    endcase
    pp = fh64_pkg::WORD_W'(pa) * fh64_pkg::WORD_W'(pb);
    // cross terms land in the upper half only
    if (step_r == ST_LL) begin
      acc_nxt = pp;
    end else begin
      acc_nxt = acc_r + {pp[fh64_pkg::HALF_W-1:0], {fh64_pkg::HALF_W{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= ST_LL;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= ST_LL;
      end else if (busy_r) begin
        case (step_r)
          ST_LL:   step_r <= ST_LH;
          ST_LH:   step_r <= ST_HL;
          ST_HL: begin
            step_r <= ST_LL;
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
          default: step_r <= ST_LL;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.op_a;
      b_r <= req.op_b;
    end
    if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign rsp.busy    = busy_r;
  assign rsp.done    = done_r;
  assign rsp.product = acc_r;

endmodule

`default_nettype wire

// ===== rtl/fast_hash_64_stream.sv =====
// fasthash64 over a stream of little-endian 64-bit message words.
//
// Input channel in_*: one word per handshake. in_tdata carries the word,
// its valid byte count, and on the first word the seed and total length;
// in_tuser flags the first word, in_tlast the final one. A word that is
// not first while no message is open is dropped.
// Output channel out_*: one hash word per message, after its final word.
//
// All 64-bit products go through one 32x32 multiplier, three partial
// products per multiply. A middle word with data takes two multiplies,
// the word mix by K and then the hash by M; a first word adds one
// (length times M), a last word adds one for the final mix, and then the
// output register is loaded.
// in_tready is high only while the sequencer is idle.
//
// Reset clears the running hash state, closes any open message and drops
// the output word. The finished hash sits in an output register; the next
// input word is taken while it waits. If the receiver still stalls when
// the following hash is ready, the sequencer holds until out_tready.
`timescale 1ns / 1ps
`default_nettype none

module fast_hash_64_stream (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output      logic         in_tready,
  // word[63:0], byte_count[67:64], seed[131:68], total_len[144:132], pad
  input  wire logic [151:0] in_tdata,
  // first[0]
  input  wire logic         in_tuser,
  input  wire logic         in_tlast,
  output      logic         out_tvalid,
  input  wire logic         out_tready,
  // hash_value[63:0]
  output      logic [63:0]  out_tdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEN,
    S_WORD,
    S_MIXW,
    S_HMUL,
    S_FIN,
    S_OUT
  } state_t;

  state_t                       state_r;
  logic                         in_msg_r, last_r, has_data_r;
  logic                         out_tvalid_r;
  fh64_pkg::word_t              hash_r, word_r, seed_r, res_r, out_data_r;
  fh64_pkg::mul_req_t           mreq;
  fh64_pkg::mul_rsp_t           mrsp;

  logic                         acc;
  fh64_pkg::word_t              in_word, in_seed, masked;
  logic [fh64_pkg::CNT_W-1:0]   in_cnt;
  logic [fh64_pkg::LEN_W-1:0]   in_len;

  assign in_word = in_tdata[63:0];
  assign in_cnt  = in_tdata[67:64];
  assign in_seed = in_tdata[131:68];
  assign in_len  = in_tdata[144:132];

  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;

  // keep only the valid bytes; counts above eight keep all
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      masked[8*i +: 8] = (in_cnt > 4'(i)) ? in_word[8*i +: 8] : 8'h00;
    end
  end

  always_comb begin
    mreq.start = 1'b0;
    mreq.op_a  = '0;
    mreq.op_b  = '0;
    case (state_r)
      S_IDLE: begin
        mreq.start = acc && in_tuser;
        mreq.op_a  = fh64_pkg::WORD_W'(in_len);
        mreq.op_b  = fh64_pkg::HASH_M;
      end
      S_WORD: begin
        mreq.start = has_data_r || last_r;
        mreq.op_a  = has_data_r ? fh64_pkg::xs_a(word_r) : fh64_pkg::xs_a(hash_r);
        mreq.op_b  = fh64_pkg::MIX_K;
      end
      S_MIXW: begin
        mreq.start = mrsp.done;
        mreq.op_a  = hash_r ^ fh64_pkg::xs_b(mrsp.product);
        mreq.op_b  = fh64_pkg::HASH_M;
      end
      S_HMUL: begin
        mreq.start = mrsp.done && last_r;
        mreq.op_a  = fh64_pkg::xs_a(mrsp.product);
        mreq.op_b  = fh64_pkg::MIX_K;
      end
      default: begin
        mreq.start = 1'b0;
      end
    endcase
  end

  fh64_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      in_msg_r     <= 1'b0;
      hash_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      // S_OUT reloads the output register itself
      if (out_tvalid_r && out_tready && (state_r != S_OUT)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            if (in_tuser) begin
              state_r <= S_LEN;
            end else if (in_msg_r) begin
              state_r <= S_WORD;
            end
          end
        end
        S_LEN: begin
          if (mrsp.done) begin
            hash_r   <= seed_r ^ mrsp.product;
            in_msg_r <= 1'b1;
            state_r  <= S_WORD;
          end
        end
        S_WORD: begin
          if (has_data_r) begin
            state_r <= S_MIXW;
          end else if (last_r) begin
            state_r <= S_FIN;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_MIXW: begin
          if (mrsp.done) begin
            state_r <= S_HMUL;
          end
        end
        S_HMUL: begin
          if (mrsp.done) begin
            hash_r  <= mrsp.product;
            state_r <= last_r ? S_FIN : S_IDLE;
          end
        end
        S_FIN: begin
          if (mrsp.done) begin
            res_r    <= fh64_pkg::xs_b(mrsp.product);
            in_msg_r <= 1'b0;
            state_r  <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_data_r   <= res_r;
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      word_r     <= masked;
      seed_r     <= in_seed;
      last_r     <= in_tlast;
      has_data_r <= (in_cnt != '0);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  a_done_waits : assert property (@(posedge clk) disable iff (!rst_n)
    mrsp.done |-> (state_r == S_LEN || state_r == S_MIXW ||
                   state_r == S_HMUL || state_r == S_FIN))
    else $error("multiplier result with no state waiting for it");

  a_idle_free : assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !mrsp.busy)
    else $error("ready while the multiplier is busy");

  a_out_from_seq : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_OUT))
    else $error("output word not loaded by the sequencer");

  a_orphan_drop : assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !in_tuser && !in_msg_r) |=> (state_r == S_IDLE))
    else $error("word outside a message was not dropped");
`endif

endmodule

`default_nettype wire

// ===== tb/hash_checker.sv =====
`timescale 1ns / 1ps

module hash_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [151:0] in_tdata,
  input  logic         in_tuser,
  input  logic         in_tlast,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [63:0]  out_tdata,
  output int           err_count,
  output int           pending
);

  typedef fh64_pkg::word_t word_t;

  localparam word_t HASH_MUL = 64'h8803_55f2_1e6d_1965;
  localparam word_t FOLD_MUL = 64'h2127_599b_f432_5c37;

  word_t hash_acc;
  bit    msg_open;
  word_t expected_hashes[$];
  int    hash_idx;

  initial begin
    err_count = 0;
    pending   = 0;
    hash_acc  = '0;
    msg_open  = 0;
    hash_idx  = 0;
  end

  function automatic word_t fold_word(input word_t v);
    v = v ^ (v >> 23);
    v = v * FOLD_MUL;
    v = v ^ (v >> 47);
    return v;
  endfunction

  task automatic report_mismatch(input string what, input word_t want, input word_t got);
    $display("%0t ns: hash #%0d %s: expected %016h, got %016h", $time, hash_idx, what, want,
             got);
    err_count++;
  endtask

  task automatic absorb_word(input logic [151:0] d, input logic first, input logic last);
    word_t      w;
    word_t      seed;
    logic [3:0] cnt;
    logic [12:0] len;
    int         nbytes;
    w    = d[63:0];
    cnt  = d[67:64];
    seed = d[131:68];
    len  = d[144:132];
    if (first) begin
      hash_acc = seed ^ (word_t'(len) * HASH_MUL);
      msg_open = 1;
    end
    if (!msg_open) return;
    // counts above eight saturate
    nbytes = (cnt > 8) ? 8 : int'(cnt);
    if (nbytes > 0) begin
      if (nbytes < 8) w &= (word_t'(1) << (8 * nbytes)) - 1;
      hash_acc ^= fold_word(w);
      hash_acc = hash_acc * HASH_MUL;
    end
    if (last) begin
      expected_hashes.push_back(fold_word(hash_acc));
      msg_open = 0;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      hash_acc = '0;
      msg_open = 0;
      expected_hashes.delete();
    end else begin
      if (in_tvalid && in_tready) absorb_word(in_tdata, in_tuser, in_tlast);
      if (out_tvalid && out_tready) begin
        if (expected_hashes.size() == 0) begin
          report_mismatch("with nothing pending", '0, out_tdata);
        end else begin
          if (out_tdata !== expected_hashes[0])
            report_mismatch("hash_value", expected_hashes[0], out_tdata);
          void'(expected_hashes.pop_front());
        end
        hash_idx++;
      end
    end
    pending = expected_hashes.size();
  end

endmodule

// ===== tb/tb_fast_hash_64_stream.sv =====
`timescale 1ns / 1ps

module tb_fast_hash_64_stream;

  typedef fh64_pkg::word_t word_t;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 550;

  logic         clk        = 0;
  logic         rst_n      = 0;
  logic         in_tvalid  = 0;
  logic         in_tready;
  logic [151:0] in_tdata   = '0;
  logic         in_tuser   = 0;
  logic         in_tlast   = 0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [63:0]  out_tdata;

  int err_count;
  int pending;
  int send_idle_pct = 18;
  int recv_idle_pct = 52;
  int items_done    = 0;
  int cycles        = 0;
  bit stim_open     = 0;

  fast_hash_64_stream dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  hash_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .err_count (err_count),
    .pending   (pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  // called at a falling edge; returns at the falling edge after the word is taken,
  // with in_tvalid still high: the next call or the caller drops it
  task automatic send_item(input word_t w, input logic [3:0] cnt, input logic first,
                           input logic last, input word_t seed, input logic [12:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= {7'b0, len, seed, cnt, w};
    in_tuser  <= first;
    in_tlast  <= last;
    while (!in_tready) @(negedge clk);
    @(negedge clk);
    if (first || stim_open) items_done++;
    if (first) stim_open = 1;
    if (stim_open && last) stim_open = 0;
  endtask

  // closes = 0 leaves the message open so the next first word drops it
  task automatic send_message(input int n_words, input int tail_cnt, input bit messy,
                              input bit closes, input word_t seed, input logic [12:0] len);
    logic [3:0] cnt;
    for (int i = 0; i < n_words; i++) begin
      if (i == n_words - 1) cnt = tail_cnt[3:0];
      else cnt = messy ? 4'($urandom_range(15)) : 4'd8;
      send_item(rand_word(), cnt, i == 0, closes && (i == n_words - 1), seed, len);
    end
  endtask

  task automatic run_random(input int target);
    int r;
    int n;
    int tail;
    while (items_done < target) begin
      r = $urandom_range(99);
      n = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
      if (r < 80) begin
        tail = $urandom_range((n == 1) ? 0 : 1, 8);
        send_message(n, tail, 0, 1, rand_word(), 13'(8 * (n - 1) + tail));
      end else if (r < 86) begin
        // not a first word: dropped unless a message is still open
        send_item(rand_word(), 4'($urandom_range(15)), 0, 1'($urandom_range(1)),
                  rand_word(), 13'($urandom_range(8191)));
      end else if (r < 93) begin
        send_message(n, 8, 0, 0, rand_word(), 13'(8 * n));
      end else begin
        send_message(n, $urandom_range(15), 1, 1, rand_word(), 13'($urandom_range(4096)));
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    send_item('1, 4'd8, 0, 1, '1, 13'd4096);
    send_message(1, 0, 0, 1, '0, 13'd0);
    send_message(1, 0, 0, 1, '1, 13'd4096);
    send_item('1, 4'd8, 1, 1, '0, 13'd8);
    send_item('0, 4'd8, 1, 1, '1, 13'd8);
    for (int c = 1; c < 8; c++) send_message(1, c, 0, 1, rand_word(), 13'(c));
    send_message(1, 9, 0, 1, rand_word(), 13'd8);
    send_message(1, 15, 0, 1, rand_word(), 13'd8);
    // a zero-byte first word and a short middle word in one message
    send_item(rand_word(), 4'd0, 1, 0, rand_word(), 13'd11);
    send_item(rand_word(), 4'd3, 0, 0, rand_word(), 13'd0);
    send_item(rand_word(), 4'd8, 0, 1, rand_word(), 13'd0);
    // open message abandoned by a new first word
    send_message(2, 8, 0, 0, rand_word(), 13'd16);
    send_message(2, 5, 0, 1, rand_word(), 13'd13);

    run_random(PHASE_ITEMS);
    send_idle_pct = 52;
    recv_idle_pct = 18;
    run_random(2 * PHASE_ITEMS);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(3 * PHASE_ITEMS);
    in_tvalid <= 0;

    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
